@@ sv/clls_pkg.sv @@
package clls_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_FIRST   = 3'd0;
  localparam req_t REQ_ADVANCE = 3'd1;
  localparam req_t REQ_READ    = 3'd2;
  localparam req_t REQ_REMOVE  = 3'd3;
  localparam req_t REQ_APPEND  = 3'd4;

endpackage

@@ sv/clls_ram.sv @@
module clls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write to the address being read is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cursor_linked_list_store.sv @@
// A request taken at a clock edge has its result on the out_ ports during the
// following cycle, marked by out_valid for that one cycle.
// Throughput: one request per cycle; busy stays low, and the entry at the cursor and the top
// of the free stack are read ahead from the link memories for the next request.
// Reset (synchronous, active low) empties the list and unsets the cursor; no clearing pass.
module cursor_linked_list_store #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  clls_pkg::req_t                  in_req_type,
  input  logic [COORD_BITS-1:0]           in_row,
  input  logic [COORD_BITS-1:0]           in_col,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [COORD_BITS-1:0]           out_row,
  output logic [COORD_BITS-1:0]           out_col,
  output logic [$clog2(CAPACITY+1)-1:0]   out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_UNSET  = 2'd0;
  localparam logic [1:0] MODE_AT     = 2'd1;
  localparam logic [1:0] MODE_BEFORE = 2'd2;

  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] wm_r, wm_nxt;

  logic                  out_valid_r;
  logic                  out_ok_r, ok_nxt;
  logic [COORD_BITS-1:0] out_row_r, row_nxt;
  logic [COORD_BITS-1:0] out_col_r, col_nxt;
  logic [CNT_W-1:0]      out_count_r;

  logic [COORD_BITS-1:0] cur_row, cur_col;
  logic [IDX_W-1:0]      cur_next, cur_prev, stack_top;

  logic                  data_we;
  logic [IDX_W-1:0]      data_waddr;
  logic                  next_we, prev_we, stack_we;
  logic [IDX_W-1:0]      next_waddr, next_wdata;
  logic [IDX_W-1:0]      prev_waddr, prev_wdata;
  logic [IDX_W-1:0]      stack_waddr, stack_wdata;
  logic [CNT_W-1:0]      sp_dec;
  logic [IDX_W-1:0]      stack_raddr;
  logic [IDX_W-1:0]      alloc;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    first_nxt   = first_r;
    last_nxt    = last_r;
    cursor_nxt  = cursor_r;
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    sp_nxt      = sp_r;
    wm_nxt      = wm_r;
    ok_nxt      = 1'b0;
    row_nxt     = '0;
    col_nxt     = '0;
    data_we     = 1'b0;
    next_we     = 1'b0;
    prev_we     = 1'b0;
    stack_we    = 1'b0;
    next_waddr  = last_r;
    next_wdata  = '0;
    prev_waddr  = '0;
    prev_wdata  = last_r;
    stack_waddr = sp_r[IDX_W-1:0];
    stack_wdata = cursor_r;
    alloc       = (sp_r != '0) ? stack_top : wm_r[IDX_W-1:0];
    data_waddr  = alloc;
    if (accept) begin
      unique case (in_req_type) inside
        clls_pkg::REQ_FIRST: begin
          if (count_r != '0) begin
            cursor_nxt = first_r;
            mode_nxt   = MODE_AT;
            ok_nxt     = 1'b1;
          end
        end
        clls_pkg::REQ_ADVANCE: begin
          if (count_r != '0) begin
            if (mode_r == MODE_BEFORE) begin
              cursor_nxt = first_r;
              mode_nxt   = MODE_AT;
              ok_nxt     = 1'b1;
            end else if (mode_r == MODE_AT && cursor_r != last_r) begin
              cursor_nxt = cur_next;
              ok_nxt     = 1'b1;
            end
          end
        end
        clls_pkg::REQ_READ, clls_pkg::REQ_REMOVE: begin
          if (count_r != '0 && mode_r == MODE_AT) begin
            row_nxt = cur_row;
            col_nxt = cur_col;
            ok_nxt  = 1'b1;
            if (in_req_type == clls_pkg::REQ_REMOVE) begin
              if (cursor_r == first_r && cursor_r == last_r) begin
                mode_nxt   = MODE_BEFORE;
                cursor_nxt = '0;
              end else if (cursor_r == first_r) begin
                first_nxt  = cur_next;
                cursor_nxt = cur_next;
              end else if (cursor_r == last_r) begin
                last_nxt   = cur_prev;
                cursor_nxt = cur_prev;
              end else begin
                next_we    = 1'b1;
                next_waddr = cur_prev;
                next_wdata = cur_next;
                prev_we    = 1'b1;
                prev_waddr = cur_next;
                prev_wdata = cur_prev;
                cursor_nxt = cur_next;
              end
              stack_we  = 1'b1;
              sp_nxt    = sp_r + CNT_W'(1);
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        clls_pkg::REQ_APPEND: begin
          if (count_r < CNT_W'(CAPACITY)) begin
            if (sp_r != '0) begin
              sp_nxt = sp_r - CNT_W'(1);
            end else begin
              wm_nxt = wm_r + CNT_W'(1);
            end
            data_we = 1'b1;
            if (count_r == '0) begin
              first_nxt = alloc;
            end else begin
              next_we    = 1'b1;
              next_wdata = alloc;
            end
            prev_we    = 1'b1;
            prev_waddr = alloc;
            last_nxt   = alloc;
            count_nxt  = count_r + CNT_W'(1);
            ok_nxt     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    sp_dec      = sp_nxt - CNT_W'(1);
    stack_raddr = sp_dec[IDX_W-1:0];
  end

  clls_ram #(.DEPTH(CAPACITY), .WIDTH(COORD_BITS)) u_row_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (in_row),
    .raddr (cursor_nxt),
    .rdata (cur_row)
  );

  clls_ram #(.DEPTH(CAPACITY), .WIDTH(COORD_BITS)) u_col_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (in_col),
    .raddr (cursor_nxt),
    .rdata (cur_col)
  );

  clls_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cursor_nxt),
    .rdata (cur_next)
  );

  clls_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (cursor_nxt),
    .rdata (cur_prev)
  );

  clls_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_free_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      last_r      <= '0;
      cursor_r    <= '0;
      mode_r      <= MODE_UNSET;
      count_r     <= '0;
      sp_r        <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      cursor_r    <= cursor_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      wm_r        <= wm_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= ok_nxt;
    out_row_r   <= row_nxt;
    out_col_r   <= col_nxt;
    out_count_r <= count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_entry_count = out_count_r;

endmodule

@@ sv/clls_checker.sv @@
module clls_checker #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 10
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input clls_pkg::req_t                in_req_type,
  input logic                          out_valid,
  input logic                          out_ok,
  input logic [COORD_BITS-1:0]         out_row,
  input logic [COORD_BITS-1:0]         out_col,
  input logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  // Every accepted transaction gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted transaction");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_row == '0 && out_col == '0))
    else $error("refused transaction returned coordinates");

  // An append is refused only when the pool is full.
  a_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == clls_pkg::REQ_APPEND) |=>
      (out_ok || out_entry_count == ($clog2(CAPACITY+1))'(CAPACITY)))
    else $error("append refused with room in the pool");

  a_unknown_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type != clls_pkg::REQ_FIRST &&
     in_req_type != clls_pkg::REQ_ADVANCE && in_req_type != clls_pkg::REQ_READ &&
     in_req_type != clls_pkg::REQ_REMOVE && in_req_type != clls_pkg::REQ_APPEND) |=> !out_ok)
    else $error("unknown request reported success");

endmodule

bind cursor_linked_list_store clls_checker #(
  .CAPACITY   (CAPACITY),
  .COORD_BITS (COORD_BITS)
) u_clls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_ok          (out_ok),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_entry_count (out_entry_count)
);

@@ test/cursor_linked_list_store_checker.sv @@
`timescale 1ns / 100ps

module cursor_linked_list_store_checker #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  clls_pkg::req_t                in_req_type,
  input  logic [COORD_BITS-1:0]         in_row,
  input  logic [COORD_BITS-1:0]         in_col,
  input  logic                          out_valid,
  input  logic                          out_ok,
  input  logic [COORD_BITS-1:0]         out_row,
  input  logic [COORD_BITS-1:0]         out_col,
  input  logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  output int                            pending,
  output int                            failures,
  output int                            results_checked,
  output int                            full_refusals,
  output int                            peak_entries
);

  import clls_pkg::*;

  localparam int LINK_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY+1);
  localparam int MAX_REPORTS = 50;

  typedef enum logic [1:0] {
    CUR_UNSET  = 2'd0,
    CUR_AT     = 2'd1,
    CUR_BEFORE = 2'd2
  } cursor_mode_t;

  typedef struct packed {
    logic                  ok;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COUNT_W-1:0]    entries;
  } list_result_t;

  logic [COORD_BITS-1:0] row_mem [CAPACITY];
  logic [COORD_BITS-1:0] col_mem [CAPACITY];
  logic [LINK_W-1:0]     next_mem[CAPACITY];
  logic [LINK_W-1:0]     prev_mem[CAPACITY];
  logic [LINK_W-1:0]     head_idx;
  logic [LINK_W-1:0]     tail_idx;
  logic [LINK_W-1:0]     free_idx;
  logic [LINK_W-1:0]     cur_idx;
  cursor_mode_t          cur_mode;
  logic [COUNT_W-1:0]    n_entries;

  list_result_t expected_results[$];

  // The free list starts as a chain through every entry in index order.
  function automatic void clear_list();
    for (int i = 0; i < CAPACITY; i++) begin
      row_mem[i]  = '0;
      col_mem[i]  = '0;
      prev_mem[i] = '0;
      next_mem[i] = LINK_W'((i + 1) % CAPACITY);
    end
    head_idx  = '0;
    tail_idx  = '0;
    free_idx  = '0;
    cur_idx   = '0;
    cur_mode  = CUR_UNSET;
    n_entries = '0;
  endfunction

  function automatic list_result_t apply_request(req_t req, logic [COORD_BITS-1:0] row,
                                                 logic [COORD_BITS-1:0] col);
    list_result_t      r;
    logic [LINK_W-1:0] e;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic              empty;
    logic              at_head;
    logic              at_tail;
    r     = '0;
    empty = (n_entries == 0);
    case (req)
      REQ_FIRST: begin
        if (!empty) begin
          cur_idx  = head_idx;
          cur_mode = CUR_AT;
          r.ok     = 1'b1;
        end
      end
      REQ_ADVANCE: begin
        if (!empty) begin
          if (cur_mode == CUR_BEFORE) begin
            cur_idx  = head_idx;
            cur_mode = CUR_AT;
            r.ok     = 1'b1;
          end else if (cur_mode == CUR_AT && cur_idx != tail_idx) begin
            cur_idx = next_mem[cur_idx];
            r.ok    = 1'b1;
          end
        end
      end
      REQ_READ, REQ_REMOVE: begin
        if (!empty && cur_mode == CUR_AT) begin
          e     = cur_idx;
          r.row = row_mem[e];
          r.col = col_mem[e];
          r.ok  = 1'b1;
          if (req == REQ_REMOVE) begin
            p       = prev_mem[e];
            n       = next_mem[e];
            at_head = (e == head_idx);
            at_tail = (e == tail_idx);
            if (at_head && at_tail) begin
              cur_mode = CUR_BEFORE;
              cur_idx  = '0;
            end else if (at_head) begin
              head_idx = n;
              cur_idx  = n;
            end else if (at_tail) begin
              tail_idx = p;
              cur_idx  = p;
            end else begin
              next_mem[p] = n;
              prev_mem[n] = p;
              cur_idx     = n;
            end
            next_mem[e] = free_idx;
            free_idx    = e;
            n_entries   = n_entries - 1'b1;
          end
        end
      end
      REQ_APPEND: begin
        if (n_entries < CAPACITY) begin
          e          = free_idx;
          free_idx   = next_mem[e];
          row_mem[e] = row;
          col_mem[e] = col;
          if (empty) begin
            head_idx    = e;
            prev_mem[e] = '0;
          end else begin
            next_mem[tail_idx] = e;
            prev_mem[e]        = tail_idx;
          end
          tail_idx  = e;
          n_entries = n_entries + 1'b1;
          r.ok      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entries = n_entries;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("mismatch at %0d ns: %s, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  initial begin
    failures        = 0;
    results_checked = 0;
    full_refusals   = 0;
    peak_entries    = 0;
    pending         = 0;
    clear_list();
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      clear_list();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_ok !== want.ok)
            report_mismatch("ok", out_ok, want.ok);
          if (out_row !== want.row)
            report_mismatch("row", out_row, want.row);
          if (out_col !== want.col)
            report_mismatch("column", out_col, want.col);
          if (out_entry_count !== want.entries)
            report_mismatch("entry count", out_entry_count, want.entries);
        end
      end
      if (start && !busy) begin
        if (in_req_type == REQ_APPEND && n_entries == CAPACITY)
          full_refusals++;
        expected_results.push_back(apply_request(in_req_type, in_row, in_col));
        if (n_entries > peak_entries)
          peak_entries = n_entries;
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ test/cursor_linked_list_store_test.sv @@
`timescale 1ns / 100ps

module cursor_linked_list_store_test;

  import clls_pkg::*;

  localparam int   COORD_BITS        = 10;
  localparam int   CAPACITY          = 64;
  localparam int   RANDOM_ITEMS      = 1800;
  localparam int   PHASE_ITEMS       = 150;
  localparam int   WATCHDOG_LIMIT    = 2000;
  localparam req_t REQ_UNKNOWN_FIRST = 3'd5;
  localparam req_t REQ_UNKNOWN_LAST  = 3'd7;

  typedef enum int {
    PH_FILL,
    PH_WALK,
    PH_DRAIN,
    PH_MIXED
  } phase_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  req_t                          in_req_type;
  logic [COORD_BITS-1:0]         in_row;
  logic [COORD_BITS-1:0]         in_col;
  logic                          out_valid;
  logic                          out_ok;
  logic [COORD_BITS-1:0]         out_row;
  logic [COORD_BITS-1:0]         out_col;
  logic [$clog2(CAPACITY+1)-1:0] out_entry_count;

  int pending;
  int failures;
  int results_checked;
  int full_refusals;
  int peak_entries;
  int sent;
  int quiet_cycles;

  cursor_linked_list_store #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_entry_count(out_entry_count)
  );

  cursor_linked_list_store_checker #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_entry_count(out_entry_count),
    .pending        (pending),
    .failures       (failures),
    .results_checked(results_checked),
    .full_refusals  (full_refusals),
    .peak_entries   (peak_entries)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cursor_linked_list_store_test failed");
        $finish;
      end
    end
  end

  task automatic send(req_t req, logic [COORD_BITS-1:0] row, logic [COORD_BITS-1:0] col);
    start       <= 1'b1;
    in_req_type <= req;
    in_row      <= row;
    in_col      <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int unsigned pick_gap(bit no_gaps);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55)
      return 0;
    else if (roll < 85)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? '1 : '0;
    return COORD_BITS'($urandom);
  endfunction

  function automatic req_t pick_request(phase_t ph);
    int roll;
    int w_app;
    int w_rem;
    int w_first;
    int w_adv;
    int w_read;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        w_app = 70; w_rem = 8; w_first = 6; w_adv = 8; w_read = 6;
      end
      PH_WALK: begin
        w_app = 10; w_rem = 5; w_first = 15; w_adv = 45; w_read = 22;
      end
      PH_DRAIN: begin
        w_app = 8; w_rem = 55; w_first = 10; w_adv = 12; w_read = 12;
      end
      default: begin
        w_app = 30; w_rem = 25; w_first = 10; w_adv = 17; w_read = 15;
      end
    endcase
    if (roll < w_app) return REQ_APPEND;
    roll -= w_app;
    if (roll < w_rem) return REQ_REMOVE;
    roll -= w_rem;
    if (roll < w_first) return REQ_FIRST;
    roll -= w_first;
    if (roll < w_adv) return REQ_ADVANCE;
    roll -= w_adv;
    if (roll < w_read) return REQ_READ;
    return req_t'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
  endfunction

  initial begin
    phase_t ph;
    bit     no_gaps;
    int     random_sent;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_req_type  <= REQ_FIRST;
    in_row       <= '0;
    in_col       <= '0;
    sent         = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Refusals on an empty list and with the cursor unset; the appends here leave four entries in the list.
    send(REQ_UNKNOWN_FIRST, '1, '1);
    send(REQ_FIRST, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    send(REQ_READ, '0, '0);
    send(REQ_REMOVE, '0, '0);
    send(REQ_APPEND, '0, '0);
    send(REQ_READ, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    idle_for(2);
    send(REQ_REMOVE, '0, '0);
    send(REQ_APPEND, '1, '1);
    send(REQ_APPEND, 10'h2AA, 10'h155);
    send(REQ_APPEND, 10'h155, 10'h2AA);
    // Walk the list, then remove from the middle, the tail, the head and the last entry.
    send(REQ_FIRST, '0, '0);
    send(REQ_READ, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    send(REQ_REMOVE, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    send(REQ_REMOVE, '0, '0);
    send(REQ_FIRST, '0, '0);
    send(REQ_REMOVE, '0, '0);
    send(REQ_REMOVE, '0, '0);
    // The cursor is now parked before the first entry.
    send(REQ_APPEND, '1, '0);
    send(REQ_READ, '0, '0);
    send(REQ_ADVANCE, '0, '0);
    send(REQ_READ, '0, '0);
    send(REQ_UNKNOWN_LAST, '1, '1);
    wait_drained();

    random_sent = 0;
    ph          = PH_FILL;
    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS && random_sent < RANDOM_ITEMS; i++) begin
        send(pick_request(ph), pick_coord(), pick_coord());
        random_sent++;
        idle_for(pick_gap(no_gaps));
      end
      if (ph == PH_DRAIN || ph == PH_WALK)
        wait_drained();
      ph = (ph == PH_MIXED) ? PH_FILL : phase_t'(ph + 1);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests through fill, walk, drain and mixed phases; %0d results compared.",
             sent, results_checked);
    $display("The list peaked at %0d entries and %0d appends met a full pool.",
             peak_entries, full_refusals);
    if (failures == 0) begin
      $display("cursor_linked_list_store_test passed");
    end else begin
      $display("cursor_linked_list_store_test failed");
    end
    $finish;
  end

endmodule
